// ===== hdl/date_difference_in_days_macros.svh =====
// Assertion macros shared by the checkers of this block.
// Each expects signals named clk and rst_n in the scope of use.
`ifndef DATE_DIFFERENCE_IN_DAYS_MACROS_SVH
`define DATE_DIFFERENCE_IN_DAYS_MACROS_SVH

// Same-cycle implication, off while in reset.
`define DDD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off while in reset.
`define DDD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also runs during reset.
`define DDD_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/ddd_pkg.sv =====
package ddd_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int COUNT_W = 23;
  // day number of 9999-12-31 is below 2**22
  localparam int DN_W    = 22;

  // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for every x below 2**14
  localparam int RECIP_SHIFT = 20;
  localparam int PROD_W      = 28;
  localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
  localparam logic [PROD_W-1:0] RECIP_100 = PROD_W'(10486);

  localparam logic [YEAR_W-1:0]  YEAR_MAX   = YEAR_W'(9999);
  localparam logic [MONTH_W-1:0] MONTH_FEB  = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_LAST = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   FEB_LEAP_LEN = DAY_W'(29);

  typedef struct packed {
    logic [YEAR_W-1:0]  start_year;
    logic [MONTH_W-1:0] start_month;
    logic [DAY_W-1:0]   start_day;
    logic [YEAR_W-1:0]  end_year;
    logic [MONTH_W-1:0] end_month;
    logic [DAY_W-1:0]   end_day;
    logic               include_end_day;
  } in_t;

  typedef struct packed {
    logic signed [COUNT_W-1:0] day_count;
    logic                      date_error;
  } out_t;

  // load enables of the three day-number stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } dn_en_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1:    len = 5'd31;
      4'd2:    len = 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] n;
    case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== hdl/ddd_day_number.sv =====
// Three-stage day number of one date (0001-01-01 is day 1) plus validity.
module ddd_day_number (
  input  logic                        clk,
  input  ddd_pkg::dn_en_t             en,
  input  logic [ddd_pkg::YEAR_W-1:0]  year,
  input  logic [ddd_pkg::MONTH_W-1:0] month,
  input  logic [ddd_pkg::DAY_W-1:0]   day,
  output logic [ddd_pkg::DN_W-1:0]    dn,
  output logic                        ok
);

  // stage 1: reciprocal products, 365 * (y - 1), range checks
  logic [ddd_pkg::YEAR_W-1:0]  y1_r, p1_r;
  logic [ddd_pkg::MONTH_W-1:0] m1_r;
  logic [ddd_pkg::DAY_W-1:0]   d1_r;
  logic [ddd_pkg::PROD_W-1:0]  yq1_r, pq1_r;
  logic [ddd_pkg::DN_W-1:0]    p365_1_r;
  logic                        rng1_r;
  logic [ddd_pkg::YEAR_W-1:0]  p_nxt;

  assign p_nxt = year - ddd_pkg::YEAR_W'(1);

  always_ff @(posedge clk) begin
    if (en.s1) begin
      y1_r     <= year;
      p1_r     <= p_nxt;
      m1_r     <= month;
      d1_r     <= day;
      yq1_r    <= ddd_pkg::PROD_W'(year) * ddd_pkg::RECIP_100;
      pq1_r    <= ddd_pkg::PROD_W'(p_nxt) * ddd_pkg::RECIP_100;
      p365_1_r <= ddd_pkg::DN_W'(p_nxt) * ddd_pkg::DN_W'(365);
      rng1_r   <= (year != '0) && (year <= ddd_pkg::YEAR_MAX) &&
                  (month != '0) && (month <= ddd_pkg::MONTH_LAST) && (day != '0);
    end
  end

  // stage 2: leap year, whole-year days, day-of-month limit
  logic [ddd_pkg::QUOT_W-1:0]  qy, qp;
  logic                        div100, leap;
  logic [ddd_pkg::DAY_W-1:0]   len;
  logic [ddd_pkg::DN_W-1:0]    base2_r;
  logic [ddd_pkg::MONTH_W-1:0] m2_r;
  logic [ddd_pkg::DAY_W-1:0]   d2_r;
  logic                        leap2_r, ok2_r;

  assign qy     = yq1_r[ddd_pkg::PROD_W-1:ddd_pkg::RECIP_SHIFT];
  assign qp     = pq1_r[ddd_pkg::PROD_W-1:ddd_pkg::RECIP_SHIFT];
  assign div100 = (ddd_pkg::YEAR_W'(qy) * ddd_pkg::YEAR_W'(100)) == y1_r;
  assign leap   = (y1_r[1:0] == 2'b00) && (!div100 || (qy[1:0] == 2'b00));
  assign len    = (m1_r == ddd_pkg::MONTH_FEB && leap) ? ddd_pkg::FEB_LEAP_LEN
                                                       : ddd_pkg::month_len(m1_r);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      base2_r <= p365_1_r + ddd_pkg::DN_W'(p1_r >> 2) - ddd_pkg::DN_W'(qp)
                 + ddd_pkg::DN_W'(qp >> 2);
      m2_r    <= m1_r;
      d2_r    <= d1_r;
      leap2_r <= leap;
      ok2_r   <= rng1_r && (d1_r <= len);
    end
  end

  // stage 3: add day of year
  logic [ddd_pkg::DN_W-1:0] dn3_r;
  logic                     ok3_r;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      dn3_r <= base2_r + ddd_pkg::DN_W'(ddd_pkg::days_before(m2_r))
               + ddd_pkg::DN_W'(d2_r)
               + ddd_pkg::DN_W'((m2_r > ddd_pkg::MONTH_FEB) && leap2_r);
      ok3_r <= ok2_r;
    end
  end

  assign dn = dn3_r;
  assign ok = ok3_r;

endmodule

// ===== hdl/date_difference_in_days.sv =====
// Gregorian date difference in days.
//
// Input channel in_valid/in_ready/in_data carries a request of two dates and
// the include-end-day flag; output channel out_valid/out_ready/out_data
// returns the signed day count and an error flag (count forced to 0 when
// either date has a bad year, month or day).
//
// Five register stages: three for the day numbers of both dates (reciprocal
// multiply, year sums, day of year), one for the subtraction and one output
// register. Requests pass through them in that order, and one request is
// taken in every cycle while out_ready does not hold the output back.
//
// Every stage holds its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up and a stall on out_ready only
// backs up as far as the pipeline is full; in_ready drops only when all five
// stages hold a request and out_ready is low. Synchronous reset clears the
// valid bits; the pipeline is empty and ready once reset is released.
module date_difference_in_days (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ddd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ddd_pkg::out_t out_data
);

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic adv1, adv2, adv3, adv4, adv5;

  assign adv5 = !v5_r || out_ready;
  assign adv4 = !v4_r || adv5;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  // nothing is taken while reset is held
  assign in_ready = adv1 && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
      if (adv5) v5_r <= v4_r;
    end
  end

  ddd_pkg::dn_en_t            dn_en;
  logic [ddd_pkg::DN_W-1:0]   dn_start, dn_end;
  logic                       ok_start, ok_end;

  assign dn_en = '{s1: adv1, s2: adv2, s3: adv3};

  ddd_day_number u_dn_start (
    .clk   (clk),
    .en    (dn_en),
    .year  (in_data.start_year),
    .month (in_data.start_month),
    .day   (in_data.start_day),
    .dn    (dn_start),
    .ok    (ok_start)
  );

  ddd_day_number u_dn_end (
    .clk   (clk),
    .en    (dn_en),
    .year  (in_data.end_year),
    .month (in_data.end_month),
    .day   (in_data.end_day),
    .dn    (dn_end),
    .ok    (ok_end)
  );

  logic inc1_r, inc2_r, inc3_r;

  always_ff @(posedge clk) begin
    if (adv1) inc1_r <= in_data.include_end_day;
    if (adv2) inc2_r <= inc1_r;
    if (adv3) inc3_r <= inc2_r;
  end

  // stage 4: end minus start
  logic signed [ddd_pkg::COUNT_W-1:0] diff4_r;
  logic                               geb4_r, err4_r, inc4_r;

  always_ff @(posedge clk) begin
    if (adv4) begin
      diff4_r <= ddd_pkg::COUNT_W'(dn_end) - ddd_pkg::COUNT_W'(dn_start);
      geb4_r  <= dn_end >= dn_start;
      err4_r  <= !(ok_start && ok_end);
      inc4_r  <= inc3_r;
    end
  end

  // stage 5: widen magnitude by one day away from zero when the end day is included, or force zero on error
  logic [ddd_pkg::COUNT_W-1:0] inc_term;
  ddd_pkg::out_t               out_data_r, out_data_nxt;

  assign inc_term = geb4_r ? ddd_pkg::COUNT_W'(inc4_r) : {ddd_pkg::COUNT_W{inc4_r}};

  always_comb begin
    out_data_nxt.date_error = err4_r;
    out_data_nxt.day_count  = err4_r ? '0 : diff4_r + $signed(inc_term);
  end

  always_ff @(posedge clk) begin
    if (adv5) out_data_r <= out_data_nxt;
  end

  assign out_valid = v5_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/ddd_checker.sv =====
`include "date_difference_in_days_macros.svh"

module ddd_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input ddd_pkg::out_t out_data
);

  `DDD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `DDD_ASSERT_NOW(a_err_zero, out_valid && out_data.date_error, out_data.day_count == '0)
  `DDD_ASSERT_NOW(a_no_stall_ready, !out_valid || out_ready, in_ready)
  `DDD_ASSERT_RST(a_reset_empty, !rst_n, !out_valid)

endmodule

bind date_difference_in_days ddd_checker u_ddd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== bench/date_difference_in_days_checker.sv =====
`timescale 1ns / 1ps

module date_difference_in_days_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  ddd_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  ddd_pkg::out_t out_data,
  output int            fail_count,
  output int            pending_count
);

  ddd_pkg::out_t expected_counts[$];
  ddd_pkg::out_t oldest;
  int            mismatches;
  int            result_idx;

  function automatic bit is_leap(input int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  // caller keeps m inside 1..12
  function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
    case (m)
      2:           return is_leap(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic bit good_date(input int unsigned y, input int unsigned m,
                                   input int unsigned d);
    if (y < 1 || y > 9999) return 1'b0;
    if (m < 1 || m > 12) return 1'b0;
    return (d >= 1) && (d <= month_length(y, m));
  endfunction

  // 0001-01-01 is day 1
  function automatic int unsigned serial_day(input int unsigned y, input int unsigned m,
                                             input int unsigned d);
    int unsigned p;
    int unsigned n;
    p = y - 1;
    n = 365 * p + p / 4 - p / 100 + p / 400;
    for (int k = 1; k < m; k++) n += month_length(y, k);
    return n + d;
  endfunction

  function automatic ddd_pkg::out_t predict_day_count(input ddd_pkg::in_t r);
    ddd_pkg::out_t o;
    int            a;
    int            b;
    int            span;
    o.day_count  = '0;
    o.date_error = 1'b1;
    if (good_date(r.start_year, r.start_month, r.start_day) &&
        good_date(r.end_year, r.end_month, r.end_day)) begin
      a = serial_day(r.start_year, r.start_month, r.start_day);
      b = serial_day(r.end_year, r.end_month, r.end_day);
      // the end-day bump goes on the magnitude, before the sign
      if (b >= a) span = b - a + int'(r.include_end_day);
      else span = -(a - b + int'(r.include_end_day));
      o.day_count  = ddd_pkg::COUNT_W'(span);
      o.date_error = 1'b0;
    end
    return o;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_counts.delete();
      mismatches    = 0;
      result_idx    = 0;
      pending_count <= 0;
      fail_count    <= 0;
    end else begin
      // retire before queuing so a same-edge request never matches itself
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        if (expected_counts.size() == 0) begin
          report_mismatch($sformatf("result %0d with no request outstanding", result_idx));
        end else begin
          oldest = expected_counts.pop_front();
          if (out_data.day_count !== oldest.day_count)
            report_mismatch($sformatf("result %0d day_count got %0d exp %0d", result_idx,
                                      out_data.day_count, oldest.day_count));
          if (out_data.date_error !== oldest.date_error)
            report_mismatch($sformatf("result %0d date_error got %0b exp %0b", result_idx,
                                      out_data.date_error, oldest.date_error));
        end
        result_idx++;
      end
      if (in_valid === 1'b1 && in_ready === 1'b1)
        expected_counts.push_back(predict_day_count(in_data));
      pending_count <= expected_counts.size();
      fail_count    <= mismatches;
    end
  end

endmodule

// ===== bench/date_difference_in_days_tb.sv =====
`timescale 1ns / 1ps

module date_difference_in_days_tb;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  ddd_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready = 1'b0;
  ddd_pkg::out_t out_data;
  int            fail_count;
  int            pending_count;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;

  always #5 clk = ~clk;

  date_difference_in_days uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  date_difference_in_days_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic ddd_pkg::in_t make_request(input int sy, input int sm, input int sd,
                                                input int ey, input int em, input int ed,
                                                input bit inc);
    ddd_pkg::in_t r;
    r.start_year      = ddd_pkg::YEAR_W'(sy);
    r.start_month     = ddd_pkg::MONTH_W'(sm);
    r.start_day       = ddd_pkg::DAY_W'(sd);
    r.end_year        = ddd_pkg::YEAR_W'(ey);
    r.end_month       = ddd_pkg::MONTH_W'(em);
    r.end_day         = ddd_pkg::DAY_W'(ed);
    r.include_end_day = inc;
    return r;
  endfunction

  function automatic logic [ddd_pkg::YEAR_W-1:0] pick_year();
    case ($urandom_range(7))
      0:       return ddd_pkg::YEAR_W'(1);
      1:       return ddd_pkg::YEAR_W'(9999);
      2:       return ddd_pkg::YEAR_W'($urandom_range(1, 2499) * 4);
      3:       return ddd_pkg::YEAR_W'($urandom_range(1, 99) * 100);
      default: return ddd_pkg::YEAR_W'($urandom_range(1, 9999));
    endcase
  endfunction

  // 29..31 land on both sides of the month length
  function automatic logic [ddd_pkg::DAY_W-1:0] pick_day();
    if ($urandom_range(9) < 8) return ddd_pkg::DAY_W'($urandom_range(1, 28));
    return ddd_pkg::DAY_W'($urandom_range(29, 31));
  endfunction

  function automatic logic [ddd_pkg::MONTH_W-1:0] bad_month();
    return $urandom_range(1) ? ddd_pkg::MONTH_W'(0)
                             : ddd_pkg::MONTH_W'($urandom_range(13, 15));
  endfunction

  function automatic logic [ddd_pkg::YEAR_W-1:0] bad_year();
    return $urandom_range(1) ? ddd_pkg::YEAR_W'(0)
                             : ddd_pkg::YEAR_W'($urandom_range(10000, 16383));
  endfunction

  function automatic ddd_pkg::in_t random_request();
    ddd_pkg::in_t r;
    int           kind;
    int           y;
    logic [63:0]  raw;
    kind = $urandom_range(99);
    if (kind < 8) begin
      raw = {$urandom, $urandom};
      r = raw[$bits(ddd_pkg::in_t)-1:0];
      return r;
    end
    r.start_year  = pick_year();
    r.start_month = ddd_pkg::MONTH_W'($urandom_range(1, 12));
    r.start_day   = pick_day();
    if ($urandom_range(1)) begin
      r.end_year = pick_year();
    end else begin
      // nearby end date: small spans of either sign
      y = int'(r.start_year) + int'($urandom_range(2)) - 1;
      if (y < 1) y = 1;
      if (y > 9999) y = 9999;
      r.end_year = ddd_pkg::YEAR_W'(y);
    end
    r.end_month = ddd_pkg::MONTH_W'($urandom_range(1, 12));
    r.end_day   = pick_day();
    if ($urandom_range(3) == 0) begin
      r.end_year  = r.start_year;
      r.end_month = r.start_month;
    end
    r.include_end_day = 1'($urandom_range(1));
    if (kind < 16) begin
      case ($urandom_range(5))
        0:       r.start_month = bad_month();
        1:       r.end_day     = '0;
        2:       r.start_year  = bad_year();
        3:       r.end_month   = bad_month();
        4:       r.start_day   = '0;
        default: r.end_year    = bad_year();
      endcase
    end
    return r;
  endfunction

  task automatic drive_request(input ddd_pkg::in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  // sender holds off until every outstanding request has returned
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    drive_request(make_request(1, 1, 1, 9999, 12, 31, 0));
    drive_request(make_request(9999, 12, 31, 1, 1, 1, 1));
    drive_request(make_request(1, 1, 1, 9999, 12, 31, 1));
    drive_request(make_request(2024, 5, 17, 2024, 5, 17, 0));
    drive_request(make_request(2024, 5, 17, 2024, 5, 17, 1));
    drive_request(make_request(2000, 2, 28, 2000, 3, 1, 0));
    drive_request(make_request(1900, 2, 28, 1900, 3, 1, 0));
    drive_request(make_request(2000, 2, 29, 2004, 2, 29, 1));
    drive_request(make_request(1900, 2, 29, 1900, 3, 1, 0));
    drive_request(make_request(2023, 6, 1, 2100, 2, 29, 0));
    drive_request(make_request(2400, 2, 29, 2399, 12, 31, 0));
    drive_request(make_request(2023, 0, 10, 2023, 5, 5, 0));
    drive_request(make_request(2023, 1, 1, 2023, 13, 1, 1));
    drive_request(make_request(2023, 15, 31, 2023, 1, 1, 0));
    drive_request(make_request(2023, 4, 31, 2023, 5, 1, 0));
    drive_request(make_request(2023, 1, 0, 2023, 1, 1, 0));
    drive_request(make_request(0, 1, 1, 2023, 1, 1, 0));
    drive_request(make_request(2023, 1, 1, 10000, 1, 1, 0));
    drive_request(make_request(16383, 15, 31, 16383, 15, 31, 1));
    drive_request(make_request(2023, 12, 31, 2024, 1, 1, 1));
    drive_request(make_request(1999, 12, 31, 2000, 1, 1, 0));
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      repeat (370) drive_request(random_request());
      drain_results();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
